// File: src/pnghlc_pkg.sv
// Package for the PNG header limit checker.
// Holds word types, verdict codes, register indexes, reset values, byte positions
// and the signature/header byte functions. No dependencies.
`default_nettype none

package pnghlc_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAX_ENCODED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WIDTH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_HEIGHT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_PIXELS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RGBA    = 3'd4;

  localparam logic [31:0] RST_MAX_ENCODED = 32'd1048576;
  localparam logic [31:0] RST_MAX_WIDTH   = 32'd256;
  localparam logic [31:0] RST_MAX_HEIGHT  = 32'd256;
  localparam logic [63:0] RST_MAX_PIXELS  = 64'd65536;
  localparam logic [63:0] RST_MAX_RGBA    = 64'd262144;

  // byte positions in the file
  localparam logic [31:0] SIG_END    = 32'd8;
  localparam logic [31:0] HDR_END    = 32'd16;
  localparam logic [31:0] WIDTH_END  = 32'd20;
  localparam logic [31:0] HEIGHT_END = 32'd24;
  localparam logic [31:0] IHDR_END   = 32'd33;

  typedef enum logic [2:0] {
    VERDICT_DECODED     = 3'd0,
    VERDICT_NOT_PNG     = 3'd1,
    VERDICT_OVER_BUDGET = 3'd2,
    VERDICT_BAD_META    = 3'd3,
    VERDICT_DECODE_FAIL = 3'd4
  } verdict_e;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       last_byte;
    logic       decode_ok;
  } in_word_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] image_width;
    logic [31:0] image_height;
  } out_word_t;

  // PNG signature
  function automatic logic [7:0] sig_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd0:    b = 8'h89;
      3'd1:    b = 8'h50;
      3'd2:    b = 8'h4e;
      3'd3:    b = 8'h47;
      3'd4:    b = 8'h0d;
      3'd5:    b = 8'h0a;
      3'd6:    b = 8'h1a;
      3'd7:    b = 8'h0a;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // IHDR length (13) and chunk type
  function automatic logic [7:0] hdr_byte(input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      3'd3:    b = 8'd13;
      3'd4:    b = 8'h49;
      3'd5:    b = 8'h48;
      3'd6:    b = 8'h44;
      3'd7:    b = 8'h52;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: src/png_header_limit_checker_unit.sv
// PNG header limit checker, top level.
// Depends on pnghlc_pkg.
//
// Usage: the input channel carries one file byte per word, with a last-byte
// mark and, on the last byte, the external decode outcome. Bytes of one file
// are sent in order; the next file starts on the word after a last byte.
// Only a last byte produces an output word: a verdict plus the header width
// and height (zero unless the signature, encoded-size and IHDR checks pass).
// Throughput: one input word per cycle while in_ready_o is high. Each byte
// updates the counter, the signature/header match flags and the width/height
// shifters. The verdict passes three pipeline registers: the file snapshot,
// the width*height product with the early checks, and the output register.
// Reset: per-file state clears and the limit registers take their defaults;
// no output word is pending.
// Stall: when out_ready_i is low the output word holds; up to three verdicts
// wait in the pipeline, and once the snapshot stage is held in_ready_o drops
// for every byte until the output moves.
// Limit registers are to be written through cfg_we_i/cfg_idx_i/cfg_data_i
// only while idle, by the user; the unit does not enforce this.
`default_nettype none

module png_header_limit_checker_unit (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     in_valid_i,
  output logic                                    in_ready_o,
  input  wire  pnghlc_pkg::in_word_t              in_data_i,
  output logic                                    out_valid_o,
  input  wire                                     out_ready_i,
  output pnghlc_pkg::out_word_t                   out_data_o,
  input  wire                                     cfg_we_i,
  input  wire  [pnghlc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire  [pnghlc_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  // limit registers
  logic [31:0] max_enc_q, max_w_q, max_h_q;
  logic [63:0] max_pix_q, max_rgba_q;

  // per-file state
  logic [31:0] cnt_q, w_q, h_q;
  logic        sig_ok_q, hdr_ok_q;
  logic [31:0] cnt_d, w_d, h_d;
  logic        sig_ok_d, hdr_ok_d;

  // stage A: file snapshot
  logic        a_vld_q;
  logic [31:0] a_size_q, a_w_q, a_h_q;
  logic        a_sig_q, a_hdr_q, a_dec_q;

  // stage B: product and early checks
  logic        b_vld_q;
  logic [63:0] b_prod_q, b_prod_d;
  logic [31:0] b_w_q, b_h_q;
  logic        b_dec_q, b_hit_q, b_dims_q, b_hit_d, b_dims_d;
  pnghlc_pkg::verdict_e b_verdict_q, b_verdict_d;

  // output
  logic                  out_vld_q;
  pnghlc_pkg::out_word_t out_q, out_d;

  logic out_free, b_free, a_free, in_acc;

  assign out_free   = !out_vld_q || out_ready_i;
  assign b_free     = !b_vld_q || out_free;
  assign a_free     = !a_vld_q || b_free;
  assign in_ready_o = a_free;
  assign in_acc     = in_valid_i && a_free;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  // byte update
  always_comb begin
    sig_ok_d = sig_ok_q;
    hdr_ok_d = hdr_ok_q;
    w_d      = w_q;
    h_d      = h_q;
    if (cnt_q < pnghlc_pkg::SIG_END) begin
      if (in_data_i.file_byte != pnghlc_pkg::sig_byte(cnt_q[2:0])) begin
        sig_ok_d = 1'b0;
      end
    end else if (cnt_q < pnghlc_pkg::HDR_END) begin
      if (in_data_i.file_byte != pnghlc_pkg::hdr_byte(cnt_q[2:0])) begin
        hdr_ok_d = 1'b0;
      end
    end else if (cnt_q < pnghlc_pkg::WIDTH_END) begin
      w_d = {w_q[23:0], in_data_i.file_byte};
    end else if (cnt_q < pnghlc_pkg::HEIGHT_END) begin
      h_d = {h_q[23:0], in_data_i.file_byte};
    end
    cnt_d = (cnt_q == '1) ? cnt_q : cnt_q + 32'd1;
  end

  // early checks in file order
  always_comb begin
    b_hit_d     = 1'b1;
    b_dims_d    = 1'b0;
    b_verdict_d = pnghlc_pkg::VERDICT_DECODED;
    if (a_size_q < pnghlc_pkg::SIG_END || !a_sig_q) begin
      b_verdict_d = pnghlc_pkg::VERDICT_NOT_PNG;
    end else if (a_size_q > max_enc_q) begin
      b_verdict_d = pnghlc_pkg::VERDICT_OVER_BUDGET;
    end else if (a_size_q < pnghlc_pkg::IHDR_END || !a_hdr_q) begin
      b_verdict_d = pnghlc_pkg::VERDICT_BAD_META;
    end else begin
      b_dims_d = 1'b1;
      if (a_w_q == '0 || a_h_q == '0) begin
        b_verdict_d = pnghlc_pkg::VERDICT_BAD_META;
      end else if (a_w_q > max_w_q || a_h_q > max_h_q) begin
        b_verdict_d = pnghlc_pkg::VERDICT_OVER_BUDGET;
      end else begin
        b_hit_d = 1'b0;
      end
    end
  end

  assign b_prod_d = 64'(a_w_q) * 64'(a_h_q);

  // budget checks and final verdict
  always_comb begin
    out_d.verdict = b_verdict_q;
    if (!b_hit_q) begin
      if (b_prod_q > max_pix_q || b_prod_q[63:62] != 2'b00) begin
        out_d.verdict = pnghlc_pkg::VERDICT_OVER_BUDGET;
      end else if ({b_prod_q[61:0], 2'b00} > max_rgba_q) begin
        out_d.verdict = pnghlc_pkg::VERDICT_OVER_BUDGET;
      end else if (!b_dec_q) begin
        out_d.verdict = pnghlc_pkg::VERDICT_DECODE_FAIL;
      end else begin
        out_d.verdict = pnghlc_pkg::VERDICT_DECODED;
      end
    end
    out_d.image_width  = b_dims_q ? b_w_q : '0;
    out_d.image_height = b_dims_q ? b_h_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_enc_q  <= pnghlc_pkg::RST_MAX_ENCODED;
      max_w_q    <= pnghlc_pkg::RST_MAX_WIDTH;
      max_h_q    <= pnghlc_pkg::RST_MAX_HEIGHT;
      max_pix_q  <= pnghlc_pkg::RST_MAX_PIXELS;
      max_rgba_q <= pnghlc_pkg::RST_MAX_RGBA;
      cnt_q      <= '0;
      w_q        <= '0;
      h_q        <= '0;
      sig_ok_q   <= 1'b1;
      hdr_ok_q   <= 1'b1;
      a_vld_q    <= 1'b0;
      b_vld_q    <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pnghlc_pkg::REG_MAX_ENCODED: max_enc_q  <= cfg_data_i[31:0];
          pnghlc_pkg::REG_MAX_WIDTH:   max_w_q    <= cfg_data_i[31:0];
          pnghlc_pkg::REG_MAX_HEIGHT:  max_h_q    <= cfg_data_i[31:0];
          pnghlc_pkg::REG_MAX_PIXELS:  max_pix_q  <= cfg_data_i;
          pnghlc_pkg::REG_MAX_RGBA:    max_rgba_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_acc) begin
        if (in_data_i.last_byte) begin
          cnt_q    <= '0;
          w_q      <= '0;
          h_q      <= '0;
          sig_ok_q <= 1'b1;
          hdr_ok_q <= 1'b1;
        end else begin
          cnt_q    <= cnt_d;
          w_q      <= w_d;
          h_q      <= h_d;
          sig_ok_q <= sig_ok_d;
          hdr_ok_q <= hdr_ok_d;
        end
      end
      if (a_free) begin
        a_vld_q <= in_acc && in_data_i.last_byte;
      end
      if (b_free) begin
        b_vld_q <= a_vld_q;
      end
      if (out_free) begin
        out_vld_q <= b_vld_q;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (a_free) begin
      a_size_q <= cnt_d;
      a_w_q    <= w_d;
      a_h_q    <= h_d;
      a_sig_q  <= sig_ok_d;
      a_hdr_q  <= hdr_ok_d;
      a_dec_q  <= in_data_i.decode_ok;
    end
    if (b_free) begin
      b_prod_q    <= b_prod_d;
      b_w_q       <= a_w_q;
      b_h_q       <= a_h_q;
      b_dec_q     <= a_dec_q;
      b_hit_q     <= b_hit_d;
      b_dims_q    <= b_dims_d;
      b_verdict_q <= b_verdict_d;
    end
    if (out_free) begin
      out_q <= out_d;
    end
  end

endmodule

`default_nettype wire

// File: src/pnghlc_checker.sv
// Port-level assertions for the PNG header limit checker, with its bind.
// Depends on pnghlc_pkg and png_header_limit_checker_unit.
`default_nettype none

module pnghlc_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              out_valid_o,
  input wire                              out_ready_i,
  input wire pnghlc_pkg::out_word_t       out_data_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed while stalled");

  // signature failure never reports dimensions
  a_not_png_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.verdict == pnghlc_pkg::VERDICT_NOT_PNG |->
      out_data_o.image_width == '0 && out_data_o.image_height == '0)
    else $error("not-png verdict with dimensions");

  // a decoded image has nonzero dimensions
  a_decoded_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.verdict == pnghlc_pkg::VERDICT_DECODED |->
      out_data_o.image_width != '0 && out_data_o.image_height != '0)
    else $error("decoded verdict with zero dimension");

  // decode failure only once the header was read
  a_fail_dims: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.verdict == pnghlc_pkg::VERDICT_DECODE_FAIL |->
      out_data_o.image_width != '0 && out_data_o.image_height != '0)
    else $error("decode-fail verdict with zero dimension");

endmodule

bind png_header_limit_checker_unit pnghlc_checker u_pnghlc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

// File: tb/tb_top.sv
// Testbench for png_header_limit_checker_unit: streams PNG-like byte files through
// the unit and checks each verdict word against a scoreboard-held predictor.
// Depends on pnghlc_pkg and the unit's RTL; stands alone otherwise.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // signature followed by IHDR length and chunk type
  localparam logic [127:0] PNG_LEAD    = 128'h89504e47_0d0a1a0a_0000000d_49484452;
  localparam int unsigned  HOLD_CYCLES = 300;
  localparam int unsigned  CYCLE_LIMIT = 400000;
  localparam int unsigned  MAX_REPORTS = 10;

  typedef enum int unsigned {FILE_GOOD, FILE_BAD_LEAD, FILE_CUT, FILE_NOISE} file_kind_e;

  class png_verdict_board;
    logic [31:0] lim_bytes;
    logic [31:0] lim_width;
    logic [31:0] lim_height;
    logic [63:0] lim_pixels;
    logic [63:0] lim_rgba;
    logic [31:0] seen_bytes;
    logic        sig_ok;
    logic        hdr_ok;
    logic [31:0] width_acc;
    logic [31:0] height_acc;
    pnghlc_pkg::out_word_t verdicts_due[$];
    int unsigned mismatches;

    function new();
      lim_bytes  = pnghlc_pkg::RST_MAX_ENCODED;
      lim_width  = pnghlc_pkg::RST_MAX_WIDTH;
      lim_height = pnghlc_pkg::RST_MAX_HEIGHT;
      lim_pixels = pnghlc_pkg::RST_MAX_PIXELS;
      lim_rgba   = pnghlc_pkg::RST_MAX_RGBA;
      mismatches = 0;
      clear_file();
    endfunction

    function void clear_file();
      seen_bytes = '0;
      sig_ok     = 1'b1;
      hdr_ok     = 1'b1;
      width_acc  = '0;
      height_acc = '0;
    endfunction

    function void write_limit(logic [pnghlc_pkg::CFG_IDX_W-1:0] idx,
                              logic [pnghlc_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        pnghlc_pkg::REG_MAX_ENCODED: lim_bytes  = data[31:0];
        pnghlc_pkg::REG_MAX_WIDTH:   lim_width  = data[31:0];
        pnghlc_pkg::REG_MAX_HEIGHT:  lim_height = data[31:0];
        pnghlc_pkg::REG_MAX_PIXELS:  lim_pixels = data;
        pnghlc_pkg::REG_MAX_RGBA:    lim_rgba   = data;
        default: ;
      endcase
    endfunction

    function pnghlc_pkg::out_word_t verdict_for(logic dec_ok);
      pnghlc_pkg::out_word_t r;
      logic [63:0] pixels;
      logic [65:0] rgba;
      logic        dims_seen;
      pixels    = 64'(width_acc) * 64'(height_acc);
      rgba      = {pixels, 2'b00};
      dims_seen = 1'b1;
      r.verdict = pnghlc_pkg::VERDICT_DECODED;
      if (seen_bytes < pnghlc_pkg::SIG_END || !sig_ok) begin
        r.verdict = pnghlc_pkg::VERDICT_NOT_PNG;
        dims_seen = 1'b0;
      end else if (seen_bytes > lim_bytes) begin
        r.verdict = pnghlc_pkg::VERDICT_OVER_BUDGET;
        dims_seen = 1'b0;
      end else if (seen_bytes < pnghlc_pkg::IHDR_END || !hdr_ok) begin
        r.verdict = pnghlc_pkg::VERDICT_BAD_META;
        dims_seen = 1'b0;
      end else if (width_acc == '0 || height_acc == '0) begin
        r.verdict = pnghlc_pkg::VERDICT_BAD_META;
      end else if (width_acc > lim_width || height_acc > lim_height) begin
        r.verdict = pnghlc_pkg::VERDICT_OVER_BUDGET;
      end else if (pixels > lim_pixels || pixels[63:62] != 2'b00) begin
        r.verdict = pnghlc_pkg::VERDICT_OVER_BUDGET;
      end else if (rgba > {2'b00, lim_rgba}) begin
        r.verdict = pnghlc_pkg::VERDICT_OVER_BUDGET;
      end else if (!dec_ok) begin
        r.verdict = pnghlc_pkg::VERDICT_DECODE_FAIL;
      end
      r.image_width  = dims_seen ? width_acc : '0;
      r.image_height = dims_seen ? height_acc : '0;
      return r;
    endfunction

    function void note_input(pnghlc_pkg::in_word_t w);
      int pos;
      pos = int'(seen_bytes);
      if (seen_bytes < pnghlc_pkg::SIG_END) begin
        if (w.file_byte != PNG_LEAD[127 - 8*pos -: 8]) sig_ok = 1'b0;
      end else if (seen_bytes < pnghlc_pkg::HDR_END) begin
        if (w.file_byte != PNG_LEAD[127 - 8*pos -: 8]) hdr_ok = 1'b0;
      end else if (seen_bytes < pnghlc_pkg::WIDTH_END) begin
        width_acc = {width_acc[23:0], w.file_byte};
      end else if (seen_bytes < pnghlc_pkg::HEIGHT_END) begin
        height_acc = {height_acc[23:0], w.file_byte};
      end
      if (seen_bytes != '1) seen_bytes++;
      if (w.last_byte) begin
        verdicts_due.push_back(verdict_for(w.decode_ok));
        clear_file();
      end
    endfunction

    function void check_result(pnghlc_pkg::out_word_t got);
      pnghlc_pkg::out_word_t want;
      if (verdicts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected word: verdict %0d width %0h height %0h",
                   $realtime, got.verdict, got.image_width, got.image_height);
        return;
      end
      want = verdicts_due.pop_front();
      if (got.verdict !== want.verdict || got.image_width !== want.image_width ||
          got.image_height !== want.image_height) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"%0t: verdict exp %0d got %0d, width exp %0h got %0h,",
                    " height exp %0h got %0h"},
                   $realtime, want.verdict, got.verdict, want.image_width,
                   got.image_width, want.image_height, got.image_height);
      end
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  pnghlc_pkg::in_word_t              in_word;
  logic                              out_valid;
  logic                              out_ready;
  pnghlc_pkg::out_word_t             out_word;
  logic                              cfg_we;
  logic [pnghlc_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [pnghlc_pkg::CFG_DATA_W-1:0] cfg_data;
  logic [7:0]                        hold_seq;
  int unsigned                       burst_left;
  int unsigned                       cycle_cnt = 0;
  logic [7:0]                        file_buf[$];
  png_verdict_board                  board;

  png_header_limit_checker_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_word),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) board.note_input(in_word);
      if (out_valid && out_ready) board.check_result(out_word);
    end
  end

  // receiver: changing stall pattern, plus one long hold-off on request
  initial begin
    int unsigned hold_left;
    int unsigned mode_left;
    int unsigned mode;
    logic [7:0]  hold_seen;
    hold_left = 0;
    mode_left = 0;
    mode      = 0;
    hold_seen = '0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(5, 60);
        end
        mode_left--;
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom);
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic push_byte(input pnghlc_pkg::in_word_t w);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      burst_left = $urandom_range(1, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_file(input logic dec_ok);
    pnghlc_pkg::in_word_t w;
    for (int i = 0; i < file_buf.size(); i++) begin
      w.file_byte = file_buf[i];
      w.last_byte = (i == file_buf.size() - 1);
      w.decode_ok = w.last_byte ? dec_ok : 1'($urandom);
      push_byte(w);
    end
  endtask

  task automatic build_png(input logic [31:0] w, input logic [31:0] h, input int unsigned tail);
    file_buf.delete();
    for (int i = 0; i < 16; i++) file_buf.push_back(PNG_LEAD[127 - 8*i -: 8]);
    for (int i = 3; i >= 0; i--) file_buf.push_back(w[8*i +: 8]);
    for (int i = 3; i >= 0; i--) file_buf.push_back(h[8*i +: 8]);
    repeat (tail) file_buf.push_back(8'($urandom));
  endtask

  task automatic cut_file(input int unsigned len);
    while (file_buf.size() > len) void'(file_buf.pop_back());
  endtask

  function automatic logic [31:0] pick_dim(input logic [31:0] limit);
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 32'd1;
      2:       return limit;
      3:       return limit + 32'd1;
      4:       return $urandom;
      5:       return '1;
      6:       return $urandom_range(1, 300);
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  task automatic random_file();
    int unsigned roll;
    int unsigned pos;
    file_kind_e  kind;
    roll = $urandom_range(0, 8);
    kind = (roll < 6) ? FILE_GOOD : file_kind_e'(roll - 5);
    build_png(pick_dim(board.lim_width), pick_dim(board.lim_height), $urandom_range(9, 14));
    case (kind)
      FILE_BAD_LEAD: begin
        pos = $urandom_range(0, 15);
        file_buf[pos] ^= 8'($urandom_range(1, 255));
      end
      FILE_CUT:   cut_file($urandom_range(1, 32));
      FILE_NOISE: begin
        file_buf.delete();
        repeat ($urandom_range(1, 12)) file_buf.push_back(8'($urandom));
      end
      default: ;
    endcase
  endtask

  task automatic random_files(input int unsigned files_min, input int unsigned bytes_min);
    int unsigned files;
    int unsigned bytes_sent;
    files      = 0;
    bytes_sent = 0;
    while (files < files_min || bytes_sent < bytes_min) begin
      random_file();
      bytes_sent += file_buf.size();
      send_file(1'($urandom));
      files++;
    end
  endtask

  task automatic load_limits(input logic [31:0] enc, input logic [31:0] w,
                             input logic [31:0] h, input logic [63:0] pix,
                             input logic [63:0] rgba);
    logic [pnghlc_pkg::CFG_IDX_W-1:0]  idxs [5];
    logic [pnghlc_pkg::CFG_DATA_W-1:0] vals [5];
    logic [pnghlc_pkg::CFG_IDX_W-1:0]  junk_idx;
    logic [pnghlc_pkg::CFG_DATA_W-1:0] junk_val;
    int unsigned                       junk_sel;
    idxs = '{pnghlc_pkg::REG_MAX_ENCODED, pnghlc_pkg::REG_MAX_WIDTH,
             pnghlc_pkg::REG_MAX_HEIGHT, pnghlc_pkg::REG_MAX_PIXELS,
             pnghlc_pkg::REG_MAX_RGBA};
    // upper half of the 32-bit limits is don't-care
    vals = '{{$urandom, enc}, {$urandom, w}, {$urandom, h}, pix, rgba};
    for (int i = 0; i < 5; i++) begin
      cfg_we   <= 1'b1;
      cfg_idx  <= idxs[i];
      cfg_data <= vals[i];
      @(posedge clk);
      board.write_limit(idxs[i], vals[i]);
    end
    // unused index, must be dropped
    junk_sel = int'(pnghlc_pkg::REG_MAX_RGBA) + $urandom_range(1, 3);
    junk_idx = junk_sel[pnghlc_pkg::CFG_IDX_W-1:0];
    junk_val = {$urandom, $urandom};
    cfg_idx  <= junk_idx;
    cfg_data <= junk_val;
    @(posedge clk);
    board.write_limit(junk_idx, junk_val);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    board = new();
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_word    <= '0;
    cfg_we     <= 1'b0;
    cfg_idx    <= '0;
    cfg_data   <= '0;
    hold_seq   <= '0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits: each check in turn
    build_png(32'd16, 32'd16, 9); send_file(1'b1);
    build_png(pnghlc_pkg::RST_MAX_WIDTH, pnghlc_pkg::RST_MAX_HEIGHT, 9); send_file(1'b0);
    build_png(32'd16, 32'd16, 9); file_buf[0] = 8'h88; cut_file(8); send_file(1'b1);
    build_png(32'd16, 32'd16, 9); file_buf[15] = 8'h72;  send_file(1'b1);
    build_png(32'd16, 32'd16, 9); cut_file(7);           send_file(1'b1);
    build_png(32'd16, 32'd16, 9); cut_file(32);          send_file(1'b0);

    // everything open: only the 64-bit pixel overflow can trip
    drain();
    load_limits('1, '1, '1, '1, '1);
    build_png(32'h8000_0000, 32'h8000_0000, 9);   send_file(1'b1);
    build_png(32'h8000_0000, 32'h7fff_ffff, 9);   send_file(1'b1);

    // encoded size at its smallest useful bound
    drain();
    load_limits(pnghlc_pkg::IHDR_END, pnghlc_pkg::RST_MAX_WIDTH, pnghlc_pkg::RST_MAX_HEIGHT,
                pnghlc_pkg::RST_MAX_PIXELS, pnghlc_pkg::RST_MAX_RGBA);
    build_png(32'd16, 32'd16, 9);  send_file(1'b1);
    build_png(32'd16, 32'd16, 10); send_file(1'b1);

    // pixel and rgba bounds
    drain();
    load_limits('1, 32'd300, 32'd300, 64'd10000, 64'd39999);
    build_png(32'd100, 32'd100, 9); send_file(1'b1);
    build_png(32'd100, 32'd101, 9); send_file(1'b1);

    // random mid-range limits, then a long output hold-off under short files
    drain();
    load_limits($urandom_range(33, 64), $urandom_range(1, 300), $urandom_range(1, 300),
                64'($urandom_range(1, 90000)), 64'($urandom_range(1, 360000)));
    hold_seq <= hold_seq + 8'd1;
    repeat (12) begin
      file_buf.delete();
      repeat ($urandom_range(1, 3)) file_buf.push_back(8'($urandom));
      send_file(1'($urandom));
    end
    random_files(2, 0);

    // all limits zero
    drain();
    load_limits('0, '0, '0, '0, '0);
    random_files(2, 0);

    drain();
    repeat (12) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/pnghlc_pkg.sv
src/png_header_limit_checker_unit.sv
src/pnghlc_checker.sv
tb/tb_top.sv
